// ===== src/bfps_pkg.sv =====
// Shared types, widths and action codes for the byte FIFO with statistics.
package bfps_pkg;

  // Payload field widths, fixed by the channel definition.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned LEVEL_W  = 7;
  localparam int unsigned DROP_W   = 16;

  // Default buffer depth in bytes.
  localparam int unsigned DEPTH_DEFAULT = 64;

  // Action codes carried by an input transfer.
  localparam logic [ACTION_W-1:0] ACT_PUSH  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STATS = 2'd2;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic load_item;  // An input transfer happens this cycle.
  } cmd_t;

endpackage : bfps_pkg

// ===== src/bfps_in_if.sv =====
// Input channel: one action per transfer, with the byte to push.
interface bfps_in_if;
  logic                          valid;
  logic                          ready;
  logic [bfps_pkg::ACTION_W-1:0] action;
  logic [bfps_pkg::BYTE_W-1:0]   push_byte;

  modport source (output valid, output action, output push_byte, input ready);
  modport sink   (input valid, input action, input push_byte, output ready);
endinterface : bfps_in_if

// ===== src/bfps_out_if.sv =====
// Output channel: one result per accepted action.
interface bfps_out_if;
  logic                         valid;
  logic                         ready;
  logic [bfps_pkg::BYTE_W-1:0]  pop_byte;
  logic                         pop_valid;
  logic                         push_accepted;
  logic [bfps_pkg::LEVEL_W-1:0] fill_level;
  logic [bfps_pkg::LEVEL_W-1:0] peak_level;
  logic [bfps_pkg::DROP_W-1:0]  drop_count;

  modport source (output valid, output pop_byte, output pop_valid, output push_accepted,
                  output fill_level, output peak_level, output drop_count, input ready);
  modport sink   (input valid, input pop_byte, input pop_valid, input push_accepted,
                  input fill_level, input peak_level, input drop_count, output ready);
endinterface : bfps_out_if

// ===== src/bfps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bfps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule : bfps_ram

// ===== src/bfps_ctrl.sv =====
// Controller: tracks whether a result is held and handles both handshakes.
module bfps_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfps_pkg::cmd_t cmd_o
);
  import bfps_pkg::*;

  localparam logic ST_EMPTY = 1'b0;
  localparam logic ST_HELD  = 1'b1;

  logic state_q;
  logic state_d;
  logic accept;

  // A new item may enter whenever the result slot is free or being emptied.
  assign in_ready_o  = (state_q == ST_EMPTY) || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == ST_HELD);
  assign cmd_o.load_item = accept;

  // Next state of the result slot.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_EMPTY: begin
        if (accept) begin
          state_d = ST_HELD;
        end
      end
      ST_HELD: begin
        if (accept) begin
          state_d = ST_HELD;
        end else if (out_ready_i) begin
          state_d = ST_EMPTY;
        end
      end
      default: state_d = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule : bfps_ctrl

// ===== src/bfps_dpath.sv =====
// Datapath: ring indexes, occupancy, statistics, byte store and result registers.
module bfps_dpath #(
  parameter int unsigned DEPTH = bfps_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bfps_pkg::cmd_t                cmd_i,
  input  logic [bfps_pkg::ACTION_W-1:0] action_i,
  input  logic [bfps_pkg::BYTE_W-1:0]   push_byte_i,
  output logic [bfps_pkg::BYTE_W-1:0]   pop_byte_o,
  output logic                          pop_valid_o,
  output logic                          push_accepted_o,
  output logic [bfps_pkg::LEVEL_W-1:0]  fill_level_o,
  output logic [bfps_pkg::LEVEL_W-1:0]  peak_level_o,
  output logic [bfps_pkg::DROP_W-1:0]   drop_count_o
);
  import bfps_pkg::*;

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

  logic [IDX_W-1:0]   wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]   rd_idx_q, rd_idx_d;
  logic [OCC_W-1:0]   occ_q, occ_d;
  logic [OCC_W-1:0]   peak_q, peak_d;
  logic [DROP_W-1:0]  drops_q, drops_d;
  logic [OCC_W-1:0]   peak_out;
  logic [DROP_W-1:0]  drops_out;

  logic               do_push;
  logic               do_pop;
  logic               do_drop;

  logic               pop_valid_q;
  logic               push_acc_q;
  logic [OCC_W-1:0]   fill_q;
  logic [OCC_W-1:0]   peak_res_q;
  logic [DROP_W-1:0]  drops_res_q;
  logic [BYTE_W-1:0]  rdata;

  // Decode the item against the current occupancy.
  assign do_push = cmd_i.load_item && (action_i == ACT_PUSH) && (occ_q < FULL_OCC);
  assign do_drop = cmd_i.load_item && (action_i == ACT_PUSH) && (occ_q == FULL_OCC);
  assign do_pop  = cmd_i.load_item && (action_i == ACT_POP) && (occ_q != '0);

  // Ring indexes, occupancy and statistics.
  always_comb begin
    wr_idx_d  = wr_idx_q;
    rd_idx_d  = rd_idx_q;
    occ_d     = occ_q;
    peak_d    = peak_q;
    drops_d   = drops_q;
    if (do_push) begin
      wr_idx_d = (wr_idx_q == LAST_IDX) ? '0 : wr_idx_q + 1'b1;
      occ_d    = occ_q + 1'b1;
      if (occ_d > peak_q) begin
        peak_d = occ_d;
      end
    end
    if (do_drop) begin
      drops_d = drops_q + 1'b1;
    end
    if (do_pop) begin
      rd_idx_d = (rd_idx_q == LAST_IDX) ? '0 : rd_idx_q + 1'b1;
      occ_d    = occ_q - 1'b1;
    end
    // Report the statistics of this item, then clear them on a statistics read.
    peak_out  = peak_d;
    drops_out = drops_d;
    if (cmd_i.load_item && (action_i == ACT_STATS)) begin
      peak_d  = '0;
      drops_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      occ_q    <= '0;
      peak_q   <= '0;
      drops_q  <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      occ_q    <= occ_d;
      peak_q   <= peak_d;
      drops_q  <= drops_d;
    end
  end

  // Byte store; a pop's byte appears on the read port together with its result.
  bfps_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (do_push),
    .waddr_i (wr_idx_q),
    .wdata_i (push_byte_i),
    .re_i    (do_pop),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  // Result registers, loaded on every input transfer.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      pop_valid_q <= do_pop;
      push_acc_q  <= do_push;
      fill_q      <= occ_d;
      peak_res_q  <= peak_out;
      drops_res_q <= drops_out;
    end
  end

  assign pop_byte_o      = pop_valid_q ? rdata : '0;
  assign pop_valid_o     = pop_valid_q;
  assign push_accepted_o = push_acc_q;
  assign fill_level_o    = LEVEL_W'(fill_q);
  assign peak_level_o    = LEVEL_W'(peak_res_q);
  assign drop_count_o    = drops_res_q;

endmodule : bfps_dpath

// ===== src/byte_fifo_with_peak_and_drop_stats_top.sv =====
// Top level of the byte FIFO with peak-occupancy and drop statistics.
//
// Usage: every transfer on in_i carries one action: push a byte, pop the
// oldest byte, or read the statistics (level, peak, drops) and clear peak
// and drops. Each accepted action yields exactly one transfer on out_o.
// A push into a full buffer drops the byte and counts it; a pop from an
// empty buffer returns pop_valid low and a zero byte.
// The result is offered in the cycle after its input transfer.
// Throughput: one action per cycle while the receiver takes each result;
// the single result register and registered store read set this figure.
// Reset clears the indexes, the level, the peak and the drop count and
// empties the result register; the byte store keeps no reset state.
// When the receiver stalls, the result is held on out_o and in_i.ready
// stays low until the result is taken; a new item may enter in the same
// cycle the held result is transferred.
module byte_fifo_with_peak_and_drop_stats_top #(
  parameter int unsigned DEPTH = bfps_pkg::DEPTH_DEFAULT
) (
  input logic        clk_i,
  input logic        rst_ni,
  bfps_in_if.sink    in_i,
  bfps_out_if.source out_o
);
  import bfps_pkg::*;

  cmd_t cmd;

  // Controller: handshakes and the result slot.
  bfps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Datapath: buffer, statistics and results.
  bfps_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .action_i        (in_i.action),
    .push_byte_i     (in_i.push_byte),
    .pop_byte_o      (out_o.pop_byte),
    .pop_valid_o     (out_o.pop_valid),
    .push_accepted_o (out_o.push_accepted),
    .fill_level_o    (out_o.fill_level),
    .peak_level_o    (out_o.peak_level),
    .drop_count_o    (out_o.drop_count)
  );

  // An input transfer never overwrites a result that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!out_o.valid || out_o.ready))
    else $error("input transfer while a stalled result is held");

  // Every input transfer offers a result in the following cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> out_o.valid)
    else $error("no result offered after an input transfer");

  // A result never reports both a stored push and a successful pop.
  a_one_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.pop_valid && out_o.push_accepted))
    else $error("result reports both a push and a pop");

  // A result without a successful pop carries a zero byte.
  a_empty_pop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.pop_valid) |-> (out_o.pop_byte == '0))
    else $error("nonzero byte on a result without a pop");

endmodule : byte_fifo_with_peak_and_drop_stats_top

// ===== tb/tb.sv =====
// Self-checking testbench for the byte FIFO with peak-occupancy and drop statistics.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfps_pkg::*;

  localparam int unsigned FIFO_DEPTH     = DEPTH_DEFAULT;
  localparam int unsigned IDX_W          = $clog2(FIFO_DEPTH);
  // Action code 3 has no meaning in the block and must leave all state alone.
  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
  localparam int unsigned RX_HOLD_CYCLES = 60;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned PHASE_ITEMS    = 100;

  // One result transfer, in the order of the output channel's fields.
  typedef struct packed {
    logic [BYTE_W-1:0]  pop_byte;
    logic               pop_valid;
    logic               push_accepted;
    logic [LEVEL_W-1:0] fill_level;
    logic [LEVEL_W-1:0] peak_level;
    logic [DROP_W-1:0]  drop_count;
  } fifo_reply_t;

  // One row of the directed stimulus; the reply is used only when known is set.
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [BYTE_W-1:0]   push_byte;
    logic                known;
    fifo_reply_t         reply;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bfps_in_if  in_ch ();
  bfps_out_if out_ch ();

  byte_fifo_with_peak_and_drop_stats_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Directed rows: reset behavior, byte extremes, every action, empty pops and
  // the spare code. Rows with obvious answers carry them typed in.
  directed_row_t directed_rows [22] = '{
    '{ACT_POP,   8'h00, 1'b1, '0},
    '{ACT_STATS, 8'h00, 1'b1, '0},
    '{ACT_SPARE, 8'hFF, 1'b1, '0},
    '{ACT_PUSH,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, 7'd1, 7'd1, 16'd0}},
    '{ACT_PUSH,  8'hFF, 1'b0, '0},
    '{ACT_PUSH,  8'h5A, 1'b0, '0},
    '{ACT_PUSH,  8'hA5, 1'b0, '0},
    '{ACT_POP,   8'h33, 1'b0, '0},
    '{ACT_SPARE, 8'h00, 1'b0, '0},
    '{ACT_POP,   8'h00, 1'b0, '0},
    '{ACT_STATS, 8'hFF, 1'b0, '0},
    '{ACT_PUSH,  8'h80, 1'b0, '0},
    '{ACT_PUSH,  8'h01, 1'b0, '0},
    '{ACT_POP,   8'h00, 1'b0, '0},
    '{ACT_POP,   8'h00, 1'b0, '0},
    '{ACT_POP,   8'h00, 1'b0, '0},
    '{ACT_POP,   8'h00, 1'b0, '0},
    '{ACT_POP,   8'hFF, 1'b0, '0},
    '{ACT_STATS, 8'h00, 1'b0, '0},
    '{ACT_PUSH,  8'h7F, 1'b0, '0},
    '{ACT_POP,   8'h00, 1'b0, '0},
    '{ACT_STATS, 8'h00, 1'b0, '0}
  };

  // Shadow copy of the buffer and its statistics.
  logic [BYTE_W-1:0] shadow_store [FIFO_DEPTH];
  logic [IDX_W-1:0]  shadow_wr;
  logic [IDX_W-1:0]  shadow_rd;
  int unsigned       shadow_level;
  int unsigned       shadow_peak;
  logic [DROP_W-1:0] shadow_drops;

  fifo_reply_t awaited_replies [$];
  int unsigned reply_errors;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned rx_hold_left;
  bit          hold_req;

  // Free-running clock.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Safety net against a hung handshake.
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  // Applies one action to the shadow state and returns the reply it causes.
  function automatic fifo_reply_t apply_action(input logic [ACTION_W-1:0] act,
                                               input logic [BYTE_W-1:0] b);
    fifo_reply_t r;
    r = '0;
    case (act)
      ACT_PUSH: begin
        if (shadow_level < FIFO_DEPTH) begin
          shadow_store[shadow_wr] = b;
          shadow_wr = (shadow_wr == IDX_W'(FIFO_DEPTH - 1)) ? '0 : shadow_wr + 1'b1;
          shadow_level++;
          if (shadow_level > shadow_peak) begin
            shadow_peak = shadow_level;
          end
          r.push_accepted = 1'b1;
        end else begin
          shadow_drops = shadow_drops + 1'b1;
        end
      end
      ACT_POP: begin
        if (shadow_level != 0) begin
          r.pop_byte  = shadow_store[shadow_rd];
          r.pop_valid = 1'b1;
          shadow_rd = (shadow_rd == IDX_W'(FIFO_DEPTH - 1)) ? '0 : shadow_rd + 1'b1;
          shadow_level--;
        end
      end
      default: ;
    endcase
    r.fill_level = LEVEL_W'(shadow_level);
    r.peak_level = LEVEL_W'(shadow_peak);
    r.drop_count = shadow_drops;
    // A statistics read reports first, then clears peak and drops to zero.
    if (act == ACT_STATS) begin
      shadow_peak  = 0;
      shadow_drops = '0;
    end
    return r;
  endfunction

  function automatic void flag_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    reply_errors++;
    if (reply_errors <= MAX_REPORTS) begin
      $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
    end
  endfunction

  // Offers one item, waits for its transfer and records the reply it must cause.
  task automatic offer(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b,
                       input logic known, input fifo_reply_t typed);
    fifo_reply_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= act;
    in_ch.push_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    predicted = apply_action(act, b);
    awaited_replies.push_back(known ? typed : predicted);
  endtask

  task automatic send(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] b);
    offer(act, b, 1'b0, '0);
  endtask

  // Changes the idling mix with the input quiet, optionally starting a long receiver hold.
  task automatic retune(input int unsigned send_pct, input int unsigned recv_pct,
                        input bit hold);
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    hold_req      = hold;
    @(negedge clk_i);
  endtask

  task automatic wait_for_replies();
    in_ch.valid <= 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk_i);
  endtask

  // Random traffic: fill bursts, drains, push or pop runs, mixed runs, statistics reads.
  task automatic random_traffic(input int unsigned items);
    int unsigned sent;
    int unsigned run;
    int unsigned pick;
    int unsigned kind;
    sent = 0;
    while (sent < items) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        // Fill to the top and push a few more so bytes get dropped.
        run = FIFO_DEPTH - shadow_level + $urandom_range(6, 1);
        repeat (run) send(ACT_PUSH, BYTE_W'($urandom));
      end else if (pick < 35) begin
        // Drain past empty.
        run = shadow_level + $urandom_range(3, 1);
        repeat (run) send(ACT_POP, BYTE_W'($urandom));
      end else if (pick < 50) begin
        run = $urandom_range(24, 1);
        repeat (run) send(ACT_PUSH, BYTE_W'($urandom));
      end else if (pick < 65) begin
        run = $urandom_range(24, 1);
        repeat (run) send(ACT_POP, BYTE_W'($urandom));
      end else if (pick < 90) begin
        run = $urandom_range(16, 1);
        repeat (run) begin
          kind = $urandom_range(99);
          if (kind < 40) begin
            send(ACT_PUSH, BYTE_W'($urandom));
          end else if (kind < 80) begin
            send(ACT_POP, BYTE_W'($urandom));
          end else if (kind < 92) begin
            send(ACT_STATS, BYTE_W'($urandom));
          end else begin
            send(ACT_SPARE, BYTE_W'($urandom));
          end
        end
      end else begin
        run = 1;
        send(ACT_STATS, BYTE_W'($urandom));
      end
      sent += run;
    end
  endtask

  // Receiver ready: random stalls, or a counted hold when one is requested.
  always @(negedge clk_i) begin
    if (hold_req) begin
      rx_hold_left = RX_HOLD_CYCLES;
      hold_req     = 1'b0;
    end
    if (rx_hold_left > 0) begin
      out_ch.ready <= 1'b0;
      rx_hold_left--;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result transfer against the oldest awaited reply.
  always @(posedge clk_i) begin : reply_check
    fifo_reply_t seen;
    fifo_reply_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.pop_byte, out_ch.pop_valid, out_ch.push_accepted,
              out_ch.fill_level, out_ch.peak_level, out_ch.drop_count};
      if (awaited_replies.size() == 0) begin
        flag_mismatch("unexpected reply, fill_level", '0, 32'(seen.fill_level));
      end else begin
        want = awaited_replies.pop_front();
        if (seen.pop_byte !== want.pop_byte)
          flag_mismatch("pop_byte", 32'(want.pop_byte), 32'(seen.pop_byte));
        if (seen.pop_valid !== want.pop_valid)
          flag_mismatch("pop_valid", 32'(want.pop_valid), 32'(seen.pop_valid));
        if (seen.push_accepted !== want.push_accepted)
          flag_mismatch("push_accepted", 32'(want.push_accepted), 32'(seen.push_accepted));
        if (seen.fill_level !== want.fill_level)
          flag_mismatch("fill_level", 32'(want.fill_level), 32'(seen.fill_level));
        if (seen.peak_level !== want.peak_level)
          flag_mismatch("peak_level", 32'(want.peak_level), 32'(seen.peak_level));
        if (seen.drop_count !== want.drop_count)
          flag_mismatch("drop_count", 32'(want.drop_count), 32'(seen.drop_count));
      end
    end
  end

  // Main sequence.
  initial begin
    in_ch.valid     = 1'b0;
    in_ch.action    = ACT_PUSH;
    in_ch.push_byte = '0;
    out_ch.ready    = 1'b0;
    reply_errors    = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    rx_hold_left    = 0;
    hold_req        = 1'b0;
    shadow_wr       = '0;
    shadow_rd       = '0;
    shadow_level    = 0;
    shadow_peak     = 0;
    shadow_drops    = '0;
    foreach (shadow_store[i]) shadow_store[i] = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table with the sender idling less than the receiver.
    retune(34, 52, 1'b0);
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].action, directed_rows[i].push_byte,
            directed_rows[i].known, directed_rows[i].reply);
    end

    // Long receiver hold while pushes keep coming, so the input must stall.
    retune(34, 52, 1'b1);
    repeat (30) send(ACT_PUSH, BYTE_W'($urandom));
    // Sender pause until every reply is in.
    wait_for_replies();
    random_traffic(PHASE_ITEMS);

    // The receiver now idles less than the sender.
    retune(52, 34, 1'b0);
    random_traffic(PHASE_ITEMS);

    // Neither side idles.
    retune(0, 0, 1'b0);
    random_traffic(PHASE_ITEMS);

    // Fill to the top, then push a few more so drops are counted and reported.
    repeat (FIFO_DEPTH - shadow_level) send(ACT_PUSH, BYTE_W'($urandom));
    send(ACT_STATS, 8'h00);
    repeat (3) send(ACT_PUSH, BYTE_W'($urandom));
    send(ACT_STATS, 8'h00);

    wait_for_replies();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (reply_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule : tb

// ===== filelist.f =====
src/bfps_pkg.sv
src/bfps_in_if.sv
src/bfps_out_if.sv
src/bfps_ram.sv
src/bfps_ctrl.sv
src/bfps_dpath.sv
src/byte_fifo_with_peak_and_drop_stats_top.sv
tb/tb.sv
